// ===== hw/rtl/msrbm_pkg.sv =====
// Shared types and constants of the media stream rate and backlog monitor.
package msrbm_pkg;

	// Event codes carried in the op field.
	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_STOP  = 3'd1;
	localparam logic [2:0] OP_VRX   = 3'd2;
	localparam logic [2:0] OP_VPLAY = 3'd3;
	localparam logic [2:0] OP_ARX   = 3'd4;
	localparam logic [2:0] OP_APLAY = 3'd5;
	localparam logic [2:0] OP_QUERY = 3'd6;

	// Configuration register indexes.
	localparam logic [2:0] REG_WINDOW_MS    = 3'd0;
	localparam logic [2:0] REG_VIDEO_PAUSE  = 3'd1;
	localparam logic [2:0] REG_AUDIO_PAUSE  = 3'd2;
	localparam logic [2:0] REG_VIDEO_DROP   = 3'd3;
	localparam logic [2:0] REG_AUDIO_DROP   = 3'd4;

	// Register reset values.
	localparam logic [15:0] WINDOW_MS_RST   = 16'd1000;
	localparam logic [15:0] VIDEO_PAUSE_RST = 16'd360;
	localparam logic [15:0] AUDIO_PAUSE_RST = 16'd600;
	localparam logic [15:0] VIDEO_DROP_RST  = 16'd720;
	localparam logic [15:0] AUDIO_DROP_RST  = 16'd1200;

	// Eight bits per byte over 1000 gives a plain division of the byte count by 125.
	localparam int unsigned KBPS_DIVISOR = 125;
	// Byte counts at or above this give a kbps value that no longer fits in 32 bits.
	localparam logic [47:0] KBPS_SAT_BYTES = 48'd536870912000;
	// Byte-digit long division: 5 digits of 8 bits cover the 39 bits that remain.
	localparam int unsigned DIV_DIGITS = 5;
	localparam int unsigned DIV_WIDTH  = 8 * DIV_DIGITS;
	// Reciprocal of 125 scaled by 2^22, exact for the 15-bit partial dividends.
	localparam logic [15:0] RECIP_125  = 16'd33555;
	localparam int unsigned RECIP_SHIFT = 22;

	// Per-event results that travel beside the bitrate division.
	typedef struct packed {
		logic        closed;
		logic [15:0] fps;
		logic        vcan;
		logic        acan;
		logic        disc;
		logic        bclr;    // start event: bitrate latch goes to zero
		logic        bclose;  // bitrate window closed: latch the quotient
		logic        sat;     // quotient would not fit in 32 bits
	} tag_t;

endpackage

// ===== hw/rtl/msrbm_div125.sv =====
// Pipelined division of a byte count by 125, one 8-bit quotient digit per stage.
module msrbm_div125 (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [msrbm_pkg::DIV_WIDTH-1:0]      in_num,
	input  msrbm_pkg::tag_t                      in_tag,
	output logic                                 out_valid,
	output logic [31:0]                          out_quo,
	output msrbm_pkg::tag_t                      out_tag
);

	localparam int unsigned N = msrbm_pkg::DIV_DIGITS;
	localparam int unsigned W = msrbm_pkg::DIV_WIDTH;

	logic                 v_q   [N+1];
	logic [W-1:0]         num_q [N+1];
	logic [6:0]           rem_q [N+1];
	msrbm_pkg::tag_t      tag_q [N+1];

	// Slot zero is the stage input; it holds no state.
	assign v_q[0]   = in_valid;
	assign num_q[0] = in_num;
	assign rem_q[0] = 7'd0;
	assign tag_q[0] = in_tag;

	for (genvar k = 0; k < N; k++) begin : g_digit
		logic [14:0] x;
		logic [30:0] prod;
		logic [7:0]  qd;
		logic [14:0] qmul;
		logic [14:0] r;

		// Partial dividend is the running remainder followed by the next byte.
		always_comb begin
			x    = {rem_q[k], num_q[k][W-1 -: 8]};
			prod = 31'(x) * 31'(msrbm_pkg::RECIP_125);
			qd   = prod[msrbm_pkg::RECIP_SHIFT +: 8];
			qmul = 15'(qd) * 15'(msrbm_pkg::KBPS_DIVISOR);
			r    = x - qmul;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		// Consumed dividend bytes are replaced by quotient digits from the bottom.
		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k+1] <= {num_q[k][W-9:0], qd};
				rem_q[k+1] <= r[6:0];
				tag_q[k+1] <= tag_q[k];
			end
		end
	end

	assign out_valid = v_q[N];
	assign out_quo   = num_q[N][31:0];
	assign out_tag   = tag_q[N];

endmodule

// ===== hw/rtl/media_stream_rate_backlog_monitor_core.sv =====
// Top level of the media stream rate and backlog monitor.
// A result reaches the master side through the input register, stage two, the divider and
// the output register. Throughput: one transaction per cycle while the master side is not
// stalling; the event state updates from stage one and the kbps division runs in a five-stage pipeline behind it.
// Reset: arst_n clears the state, the pipeline valid bits and the latched rates, and
// loads the registers with their default thresholds.
module media_stream_rate_backlog_monitor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,    // op[2:0], frame_bytes[26:3], now_ms[74:27], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,    // window_closed[0], play_fps[16:1], bitrate_kbps[48:17],
	                                // video_can_receive[49], audio_can_receive[50],
	                                // disconnected[51], zero pad
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// The whole pipeline moves as one: it advances whenever the output register is
	// empty or its transaction is being taken.
	logic adv;

	// Configuration registers.
	logic [15:0] win_q, vpause_q, apause_q, vdrop_q, adrop_q;

	// Stage one holds the accepted input transaction.
	logic        v_s1;
	logic [2:0]  op_s1;
	logic [23:0] bytes_s1;
	logic [47:0] now_s1;

	// Event state.
	logic        running_q;
	logic [31:0] vrx_cnt_q, vpl_cnt_q, arx_cnt_q, apl_cnt_q;
	logic [31:0] pws_q;      // played count at fps window start
	logic [47:0] fws_q;      // fps window start time, zero means not started
	logic [15:0] fps_q;
	logic [47:0] bt_q;       // received byte total, wraps at 48 bits
	logic [47:0] bas_q;      // byte total at bitrate window start
	logic [47:0] bws_q;      // bitrate window start time, zero means not started

	// Next-state and result logic of the event in stage one.
	logic        running_n;
	logic [31:0] vrx_n, vpl_n, arx_n, apl_n, pws_n;
	logic [47:0] fws_n, bt_n, bas_n, bws_n;
	logic [15:0] fps_n;
	logic [48:0] fps_age, br_age;
	logic        fps_exp, br_exp;
	logic [31:0] vpl_diff;
	logic [31:0] vb, ab;
	logic        vpause_hit, apause_hit, vdrop_hit, adrop_hit;
	msrbm_pkg::tag_t tag_n;
	logic [47:0] bas_old;    // window-start byte total that the closing diff is taken from

	// Stage two feeds the divider.
	logic            v_s2;
	msrbm_pkg::tag_t tag_s2;
	logic [47:0]     bt_s2, bas_s2;
	logic [47:0]     bdiff;
	msrbm_pkg::tag_t tag_div;

	// Divider output.
	logic            v_div;
	logic [31:0]     quo_div;
	msrbm_pkg::tag_t tag_dout;

	// Output register.
	logic        m_valid_q;
	logic        closed_q;
	logic [15:0] fps_out_q;
	logic [31:0] kbps_q;     // also serves as the latched bitrate
	logic        vcan_q, acan_q, disc_q;
	logic [31:0] kbps_n;

	assign adv      = !m_valid_q || m_tready;
	assign s_tready = adv;

	// Configuration writes. Indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= msrbm_pkg::WINDOW_MS_RST;
			vpause_q <= msrbm_pkg::VIDEO_PAUSE_RST;
			apause_q <= msrbm_pkg::AUDIO_PAUSE_RST;
			vdrop_q  <= msrbm_pkg::VIDEO_DROP_RST;
			adrop_q  <= msrbm_pkg::AUDIO_DROP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				msrbm_pkg::REG_WINDOW_MS:   win_q    <= cfg_data;
				msrbm_pkg::REG_VIDEO_PAUSE: vpause_q <= cfg_data;
				msrbm_pkg::REG_AUDIO_PAUSE: apause_q <= cfg_data;
				msrbm_pkg::REG_VIDEO_DROP:  vdrop_q  <= cfg_data;
				msrbm_pkg::REG_AUDIO_DROP:  adrop_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= s_tdata[2:0];
			bytes_s1 <= s_tdata[26:3];
			now_s1   <= s_tdata[74:27];
		end
	end

	// A window closes only once it has a start time, the clock has moved past it, and
	// the elapsed time is strictly above the window length. The spare top bit of the
	// age catches time running backwards. A window with no start time just opens at
	// the current time.
	always_comb begin
		fps_age = {1'b0, now_s1} - {1'b0, fws_q};
		br_age  = {1'b0, now_s1} - {1'b0, bws_q};
		fps_exp = (fws_q != 48'd0) && !fps_age[48] && (fps_age[47:0] > {32'd0, win_q});
		br_exp  = (bws_q != 48'd0) && !br_age[48] && (br_age[47:0] > {32'd0, win_q});
	end

	always_comb begin
		running_n = running_q;
		vrx_n     = vrx_cnt_q;
		vpl_n     = vpl_cnt_q;
		arx_n     = arx_cnt_q;
		apl_n     = apl_cnt_q;
		pws_n     = pws_q;
		fws_n     = fws_q;
		fps_n     = fps_q;
		bt_n      = bt_q;
		bas_n     = bas_q;
		bws_n     = bws_q;
		bas_old   = bas_q;
		tag_n     = '0;
		vpl_diff  = vpl_cnt_q + 32'd1 - pws_q;

		case (op_s1)
			msrbm_pkg::OP_START: begin
				// Start sets running and clears everything else, including both windows and the latched rates.
				running_n  = 1'b1;
				vrx_n      = '0;
				vpl_n      = '0;
				arx_n      = '0;
				apl_n      = '0;
				pws_n      = '0;
				fws_n      = '0;
				fps_n      = '0;
				bt_n       = '0;
				bas_n      = '0;
				bws_n      = '0;
				tag_n.bclr = 1'b1;
			end
			msrbm_pkg::OP_STOP: begin
				// Stop keeps the windows and the latched rates.
				running_n = 1'b0;
				vrx_n     = '0;
				vpl_n     = '0;
				arx_n     = '0;
				apl_n     = '0;
			end
			msrbm_pkg::OP_VRX: begin
				vrx_n = vrx_cnt_q + 32'd1;
				bt_n  = bt_q + {24'd0, bytes_s1};
				if (br_exp) begin
					bas_n        = bt_n;
					bws_n        = now_s1;
					tag_n.closed = 1'b1;
					tag_n.bclose = 1'b1;
				end else if (bws_q == 48'd0) begin
					bws_n = now_s1;
				end
			end
			msrbm_pkg::OP_VPLAY: begin
				vpl_n = vpl_cnt_q + 32'd1;
				if (fps_exp) begin
					fps_n        = (vpl_diff[31:16] != 16'd0) ? 16'hFFFF : vpl_diff[15:0];
					pws_n        = vpl_n;
					fws_n        = now_s1;
					tag_n.closed = 1'b1;
				end else if (fws_q == 48'd0) begin
					fws_n = now_s1;
				end
			end
			msrbm_pkg::OP_ARX:   arx_n = arx_cnt_q + 32'd1;
			msrbm_pkg::OP_APLAY: apl_n = apl_cnt_q + 32'd1;
			msrbm_pkg::OP_QUERY: ;
			default: ;
		endcase

		// Backlogs are the wrapped count differences read as signed values, checked
		// against thresholds that are never negative in 32 bits.
		vb         = vrx_n - vpl_n;
		ab         = arx_n - apl_n;
		vpause_hit = $signed(vb) >= $signed({16'd0, vpause_q});
		apause_hit = $signed(ab) >= $signed({16'd0, apause_q});
		vdrop_hit  = $signed(vb) >= $signed({16'd0, vdrop_q});
		adrop_hit  = $signed(ab) >= $signed({16'd0, adrop_q});

		tag_n.fps  = fps_n;
		tag_n.vcan = !(running_n && vpause_hit);
		tag_n.acan = !(running_n && apause_hit);
		tag_n.disc = vdrop_hit || adrop_hit;
	end

	// State registers update only when the event in stage one moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			vrx_cnt_q <= '0;
			vpl_cnt_q <= '0;
			arx_cnt_q <= '0;
			apl_cnt_q <= '0;
			pws_q     <= '0;
			fws_q     <= '0;
			fps_q     <= '0;
			bt_q      <= '0;
			bas_q     <= '0;
			bws_q     <= '0;
		end else if (adv && v_s1) begin
			running_q <= running_n;
			vrx_cnt_q <= vrx_n;
			vpl_cnt_q <= vpl_n;
			arx_cnt_q <= arx_n;
			apl_cnt_q <= apl_n;
			pws_q     <= pws_n;
			fws_q     <= fws_n;
			fps_q     <= fps_n;
			bt_q      <= bt_n;
			bas_q     <= bas_n;
			bws_q     <= bws_n;
		end
	end

	// Stage two: carry the byte totals so the window difference is taken from registered values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= tag_n;
			bt_s2  <= bt_n;
			bas_s2 <= bas_old;
		end
	end

	// The byte difference wraps at 48 bits. Anything at or above the saturation point
	// is flagged here, so only quotients of values below 125 * 2^32 are ever latched.
	always_comb begin
		bdiff       = bt_s2 - bas_s2;
		tag_div     = tag_s2;
		tag_div.sat = bdiff >= msrbm_pkg::KBPS_SAT_BYTES;
	end

	msrbm_div125 u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s2),
		.in_num    ({1'b0, bdiff[38:0]}),
		.in_tag    (tag_div),
		.out_valid (v_div),
		.out_quo   (quo_div),
		.out_tag   (tag_dout)
	);

	// The latched bitrate lives in the output register: events reach it in order, so
	// each result sees every earlier start and window close.
	always_comb begin
		if (tag_dout.bclr) begin
			kbps_n = '0;
		end else if (tag_dout.bclose) begin
			kbps_n = tag_dout.sat ? 32'hFFFF_FFFF : quo_div;
		end else begin
			kbps_n = kbps_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			kbps_q    <= '0;
		end else if (adv) begin
			m_valid_q <= v_div;
			if (v_div) begin
				kbps_q <= kbps_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_div) begin
			closed_q  <= tag_dout.closed;
			fps_out_q <= tag_dout.fps;
			vcan_q    <= tag_dout.vcan;
			acan_q    <= tag_dout.acan;
			disc_q    <= tag_dout.disc;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, disc_q, acan_q, vcan_q, kbps_q, fps_out_q, closed_q};

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the media stream rate and backlog monitor core.
module tb_top;
	import msrbm_pkg::*;

	// Op code 7 has no name in the package; the block treats it like a query.
	localparam logic [2:0] OP_SPARE = 3'd7;

	// Margin that lets the pipeline settle after the last expected result has come.
	localparam int DRAIN_CYCLES = 12;
	// A correct run is about 1300 transactions plus a few drains; this limit leaves
	// a wide margin over that.
	localparam int CYCLE_LIMIT  = 200_000;
	localparam int MAX_REPORTS  = 10;

	// Frames of the largest size in one bitrate window, and plays that set the
	// window-start mark before a stop clears the played count.
	localparam int BIG_FRAMES  = 32;
	localparam int EARLY_PLAYS = 40;

	localparam logic [23:0] BYTES_MAX = 24'hFF_FFFF;
	localparam logic [47:0] TIME_MAX  = 48'hFFFF_FFFF_FFFF;

	// One result transaction, unpacked from m_tdata.
	typedef struct packed {
		logic        closed;
		logic [15:0] fps;
		logic [31:0] kbps;
		logic        vcan;
		logic        acan;
		logic        disc;
	} status_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [55:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	media_stream_rate_backlog_monitor_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Monitor model: registers, counters, windows and latched rates.
	// ------------------------------------------------------------------
	logic [15:0] win_ms_cfg     = WINDOW_MS_RST;
	logic [15:0] vid_pause_cfg  = VIDEO_PAUSE_RST;
	logic [15:0] aud_pause_cfg  = AUDIO_PAUSE_RST;
	logic [15:0] vid_drop_cfg   = VIDEO_DROP_RST;
	logic [15:0] aud_drop_cfg   = AUDIO_DROP_RST;

	logic        on_air         = 1'b0;
	logic [31:0] vid_rx_count   = '0;
	logic [31:0] vid_play_count = '0;
	logic [31:0] aud_rx_count   = '0;
	logic [31:0] aud_play_count = '0;
	logic [31:0] play_mark      = '0;
	logic [47:0] fps_since      = '0;
	logic [15:0] fps_latched    = '0;
	logic [47:0] byte_total     = '0;
	logic [47:0] byte_mark      = '0;
	logic [47:0] kbps_since     = '0;
	logic [31:0] kbps_latched   = '0;

	status_t expected_status_q[$];
	int      mismatch_count = 0;
	int      cycle_count    = 0;
	int      burst_left     = 0;

	// Applies one event to the model and works out the status the block reports.
	task automatic predict_status(input logic [2:0] op, input logic [23:0] bytes,
			input logic [47:0] now, output status_t st);
		logic [31:0] vid_diff, aud_diff, play_diff;
		logic [47:0] byte_diff;
		logic [63:0] kbps;
		int          vid_backlog, aud_backlog;
		st = '0;
		case (op)
			OP_START: begin
				on_air         = 1'b1;
				vid_rx_count   = '0;
				vid_play_count = '0;
				aud_rx_count   = '0;
				aud_play_count = '0;
				play_mark      = '0;
				fps_since      = '0;
				fps_latched    = '0;
				byte_total     = '0;
				byte_mark      = '0;
				kbps_since     = '0;
				kbps_latched   = '0;
			end
			OP_STOP: begin
				// Stop leaves both windows and the latched rates alone.
				on_air         = 1'b0;
				vid_rx_count   = '0;
				vid_play_count = '0;
				aud_rx_count   = '0;
				aud_play_count = '0;
			end
			OP_VRX: begin
				vid_rx_count = vid_rx_count + 32'd1;
				byte_total   = byte_total + 48'(bytes);
				// A zero start means the window opens now.
				if (kbps_since == '0)
					kbps_since = now;
				if (now > kbps_since && (now - kbps_since) > 48'(win_ms_cfg)) begin
					byte_diff = byte_total - byte_mark;
					kbps = (64'(byte_diff) * 64'd8) / 64'd1000;
					kbps_latched = (kbps > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : kbps[31:0];
					byte_mark  = byte_total;
					kbps_since = now;
					st.closed  = 1'b1;
				end
			end
			OP_VPLAY: begin
				vid_play_count = vid_play_count + 32'd1;
				if (fps_since == '0)
					fps_since = now;
				if (now > fps_since && (now - fps_since) > 48'(win_ms_cfg)) begin
					play_diff   = vid_play_count - play_mark;
					fps_latched = (play_diff > 32'hFFFF) ? 16'hFFFF : play_diff[15:0];
					play_mark   = vid_play_count;
					fps_since   = now;
					st.closed   = 1'b1;
				end
			end
			OP_ARX:   aud_rx_count = aud_rx_count + 32'd1;
			OP_APLAY: aud_play_count = aud_play_count + 32'd1;
			default: ;
		endcase
		// Backlogs are the wrapped differences read as signed 32-bit numbers.
		vid_diff    = vid_rx_count - vid_play_count;
		aud_diff    = aud_rx_count - aud_play_count;
		vid_backlog = vid_diff;
		aud_backlog = aud_diff;
		st.fps  = fps_latched;
		st.kbps = kbps_latched;
		st.vcan = !(on_air && vid_backlog >= int'(vid_pause_cfg));
		st.acan = !(on_air && aud_backlog >= int'(aud_pause_cfg));
		st.disc = (vid_backlog >= int'(vid_drop_cfg)) || (aud_backlog >= int'(aud_drop_cfg));
	endtask

	task automatic log_mismatch(input string what, input status_t want, input status_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t %s: expected closed=%0d fps=%0d kbps=%0d vcan=%0d acan=%0d disc=%0d",
				$time, what, want.closed, want.fps, want.kbps, want.vcan, want.acan,
				want.disc);
			$display("%0t %s: actual   closed=%0d fps=%0d kbps=%0d vcan=%0d acan=%0d disc=%0d",
				$time, what, got.closed, got.fps, got.kbps, got.vcan, got.acan, got.disc);
		end
	endtask

	// Everything is sampled at the rising edge, where the inputs set up at the
	// falling edge are stable. A result transaction is checked before the input
	// transaction of the same edge is predicted; with the registered pipeline between
	// them the two never belong together.
	always @(posedge clk) begin : status_check
		status_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.closed = m_tdata[0];
				got.fps    = m_tdata[16:1];
				got.kbps   = m_tdata[48:17];
				got.vcan   = m_tdata[49];
				got.acan   = m_tdata[50];
				got.disc   = m_tdata[51];
				if (expected_status_q.size() == 0) begin
					log_mismatch("unexpected result", '0, got);
				end else begin
					want = expected_status_q.pop_front();
					if (got !== want)
						log_mismatch("status mismatch", want, got);
				end
			end
			if (s_tvalid && s_tready) begin
				predict_status(s_tdata[2:0], s_tdata[26:3], s_tdata[74:27], want);
				expected_status_q.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW_MS:   win_ms_cfg    = cfg_data;
					REG_VIDEO_PAUSE: vid_pause_cfg = cfg_data;
					REG_AUDIO_PAUSE: aud_pause_cfg = cfg_data;
					REG_VIDEO_DROP:  vid_drop_cfg  = cfg_data;
					REG_AUDIO_DROP:  aud_drop_cfg  = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// The receiver walks through an eight-bit ready pattern, picking a new one
	// each time rx_phase wraps. Every pattern is at least half ready, so stalls stay
	// short, and the all-ready pattern gives stretches with no stall.
	logic [7:0] rx_pattern = 8'hFF;
	int         rx_phase   = 0;

	always @(negedge clk) begin
		if (rx_phase == 0) begin
			case ($urandom_range(0, 4))
				0: rx_pattern = 8'hFF;
				1: rx_pattern = 8'hEE;
				2: rx_pattern = 8'hAA;
				3: rx_pattern = 8'h93;
				default: rx_pattern = 8'($urandom) | 8'h55;
			endcase
		end
		rx_phase = (rx_phase + 1) % 128;
		m_tready <= rx_pattern[0];
		rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
	end

	// ------------------------------------------------------------------
	// Shared drivers. All of them are entered and left at a falling edge.
	// ------------------------------------------------------------------

	// Sends one event. The sender works in bursts; between bursts tvalid drops
	// for a random pause. Within a burst tvalid stays high from one transaction to
	// the next.
	task automatic send_event(input logic [2:0] op, input logic [23:0] bytes,
			input logic [47:0] now);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
			burst_left = ($urandom_range(0, 99) < 20) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, now, bytes, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Holds the sender off until every expected result has come, then lets the
	// pipeline settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_status_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [2:0] index, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_registers(input logic [15:0] window, input logic [15:0] vpause,
			input logic [15:0] apause, input logic [15:0] vdrop, input logic [15:0] adrop);
		wait_drained();
		write_register(REG_WINDOW_MS, window);
		write_register(REG_VIDEO_PAUSE, vpause);
		write_register(REG_AUDIO_PAUSE, apause);
		write_register(REG_VIDEO_DROP, vdrop);
		write_register(REG_AUDIO_DROP, adrop);
	endtask

	// Random sessions. Most of the traffic is a running stream whose clock moves
	// forward in steps scaled to the window, so that windows keep closing; runs of
	// receive-heavy or play-heavy traffic push the backlogs around the thresholds.
	// Now and then the clock jumps backwards, reads zero, lands just past a window
	// edge or takes any value at all, and stray starts, stops and queries come in.
	task automatic random_traffic(input int n_items);
		logic [47:0] clock_ms, now;
		logic [23:0] bytes;
		logic [2:0]  op;
		int          span, pick, rx_pct, bias_left, bias_mode;
		span      = (win_ms_cfg == 0) ? 1 : int'(win_ms_cfg);
		clock_ms  = {16'($urandom), $urandom};
		bias_left = 0;
		bias_mode = 0;
		if ($urandom_range(0, 9) != 0)
			send_event(OP_START, 24'($urandom), clock_ms);
		for (int i = 0; i < n_items; i++) begin
			// Pressure point: halfway through, let every result come home.
			if (i == n_items / 2)
				wait_drained();
			if (bias_left == 0) begin
				bias_left = $urandom_range(10, 200);
				bias_mode = $urandom_range(0, 2);
			end
			bias_left--;

			pick = $urandom_range(0, 99);
			if (pick < 1)
				op = OP_START;
			else if (pick < 2)
				op = OP_STOP;
			else if (pick < 5)
				op = OP_QUERY;
			else if (pick < 6)
				op = OP_SPARE;
			else begin
				rx_pct = (bias_mode == 1) ? 80 : (bias_mode == 2) ? 25 : 50;
				if ($urandom_range(0, 1))
					op = ($urandom_range(0, 99) < rx_pct) ? OP_VRX : OP_VPLAY;
				else
					op = ($urandom_range(0, 99) < rx_pct) ? OP_ARX : OP_APLAY;
			end

			pick = $urandom_range(0, 99);
			if (pick < 10)
				bytes = '0;
			else if (pick < 20)
				bytes = BYTES_MAX;
			else if (pick < 60)
				bytes = 24'($urandom_range(0, 5000));
			else
				bytes = 24'($urandom);

			pick = $urandom_range(0, 99);
			if (pick < 84)
				clock_ms = clock_ms + 48'($urandom_range(0, span / 3 + 1));
			else if (pick < 89)
				clock_ms = clock_ms - 48'($urandom_range(1, span + 1));
			else if (pick < 95)
				clock_ms = clock_ms + 48'(span) + 48'($urandom_range(0, 2));
			else if (pick < 98)
				clock_ms = {16'($urandom), $urandom};
			now = (pick >= 98) ? '0 : clock_ms;

			send_event(op, bytes, now);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Field extremes, every op and the window edge cases with reset registers.
	task automatic test_directed();
		send_event(OP_QUERY, BYTES_MAX, '0);
		send_event(OP_SPARE, '0, TIME_MAX);
		// Received before any start at time zero: the window sentinel stays zero.
		send_event(OP_VRX, BYTES_MAX, '0);
		send_event(OP_START, '0, 48'd5);
		send_event(OP_VRX, BYTES_MAX, 48'd1);
		send_event(OP_VPLAY, '0, 48'd1);
		send_event(OP_ARX, '0, 48'd1);
		send_event(OP_APLAY, '0, 48'd1);
		// Exactly one window later is not enough; one more millisecond closes it.
		send_event(OP_VRX, '0, 48'd1001);
		send_event(OP_VRX, 24'd1000, 48'd1002);
		send_event(OP_VPLAY, '0, 48'd1002);
		// Time going backwards never closes a window.
		send_event(OP_VRX, 24'h80_0000, 48'd500);
		send_event(OP_VPLAY, '0, 48'd500);
		send_event(OP_VPLAY, 24'h55_AAAA, TIME_MAX);
		// More audio played than received gives a negative backlog.
		send_event(OP_APLAY, '0, '0);
		send_event(OP_APLAY, '0, 48'h8000_0000_0000);
		// Stop keeps the window starts, so a play now sits before its window.
		send_event(OP_STOP, BYTES_MAX, 48'd2000);
		send_event(OP_VPLAY, '0, 48'd2000);
		send_event(OP_QUERY, '0, 48'h5555_5555_5555);
		send_event(OP_START, '0, 48'hAAAA_AAAA_AAAA);
		send_event(OP_VRX, 24'd123, '0);
		send_event(OP_VRX, 24'd456, '0);
		wait_drained();
	endtask

	// Pushes a large byte count through one bitrate window. A stop then clears the
	// played count but keeps the window-start mark, so the next play-rate
	// difference wraps below zero and saturates.
	task automatic test_rate_saturation();
		logic [47:0] t0, t1, t2;
		t0 = 48'd1_000_000;
		t1 = t0 + 48'(win_ms_cfg) + 48'd1;
		t2 = t1 + 48'(win_ms_cfg) + 48'd2;
		send_event(OP_START, '0, t0);
		for (int i = 0; i < BIG_FRAMES; i++)
			send_event(OP_VRX, BYTES_MAX, t0);
		for (int i = 0; i < EARLY_PLAYS; i++)
			send_event(OP_VPLAY, '0, t0);
		send_event(OP_VRX, BYTES_MAX, t1);
		send_event(OP_VPLAY, '0, t1);
		send_event(OP_STOP, '0, t1);
		send_event(OP_VPLAY, '0, t2);
		send_event(OP_VRX, BYTES_MAX, t2);
		send_event(OP_QUERY, '0, t2);
		wait_drained();
	endtask

	task automatic test_random_defaults();
		random_traffic(230);
	endtask

	// Smallest legal settings: one-millisecond windows, every threshold at one.
	task automatic test_tight_thresholds();
		set_registers(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		random_traffic(230);
	endtask

	// Largest settings: nothing ever pauses or drops.
	task automatic test_wide_thresholds();
		set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_traffic(230);
	endtask

	// All registers at zero: any later time closes a window and any backlog that
	// is not negative meets its threshold. Writes to the unused indexes must not
	// disturb anything.
	task automatic test_zero_registers();
		set_registers('0, '0, '0, '0, '0);
		for (int k = 1; k <= 3; k++)
			write_register(REG_AUDIO_DROP + 3'(k), 16'($urandom));
		random_traffic(230);
	endtask

	task automatic test_random_settings();
		logic [15:0] vpause, apause;
		vpause = 16'($urandom_range(1, 20));
		apause = 16'($urandom_range(1, 20));
		set_registers(16'($urandom_range(1, 3000)), vpause, apause,
			vpause + 16'($urandom_range(0, 20)), apause + 16'($urandom_range(0, 20)));
		random_traffic(230);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_directed();
		test_rate_saturation();
		test_random_defaults();
		test_tight_thresholds();
		test_wide_thresholds();
		test_zero_registers();
		test_random_settings();

		wait_drained();
		if (mismatch_count == 0 && expected_status_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== media_stream_rate_backlog_monitor_core.f =====
hw/rtl/msrbm_pkg.sv
hw/rtl/msrbm_div125.sv
hw/rtl/media_stream_rate_backlog_monitor_core.sv
test/tb_top.sv
